[src/rtcm3_pkg.sv]
// ---------------------------------------------------------------------------
// rtcm3_pkg: shared types, constants and the CRC-24Q byte step
// Used by the front classifier, the beat queue and the CRC back end.
// ---------------------------------------------------------------------------
`default_nettype none

package rtcm3_pkg;

    localparam logic [7:0]  PREAMBLE   = 8'hD3;
    localparam logic [7:0]  LEN1_MASK  = 8'hFC;
    localparam logic [24:0] CRC_POLY   = 25'h1864CFB;

    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);
    localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [9:0]  CRC_BYTES  = 10'd3;

    // status codes of a result beat
    localparam logic [1:0]  STATUS_GOOD     = 2'd0;
    localparam logic [1:0]  STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0]  STATUS_REJECTED = 2'd2;

    // what the back end does with a queued byte
    typedef enum logic [1:0] {
        KIND_START = 2'd0,  // preamble: CRC restarts from zero
        KIND_CONT  = 2'd1,  // frame byte: CRC continues
        KIND_LAST  = 2'd2   // last CRC byte: CRC continues, result is issued
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [11:0] msg_num;
        logic [9:0]  length;
    } qentry_t;

    // CRC-24Q, MSB first, one byte
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc,
                                                input logic [7:0]  b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (int i = 0; i < 8; i++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
                c = c ^ CRC_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage

`default_nettype wire

[src/rtcm3_front.sv]
// ---------------------------------------------------------------------------
// rtcm3_front: frame parser
// Tracks preamble, header, payload and CRC phases; tags each frame byte.
// ---------------------------------------------------------------------------
`default_nettype none

module rtcm3_front
    import rtcm3_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    byte_valid,
    input  wire logic [7:0] byte_data,
    output logic         push,
    output qentry_t      push_entry
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN1,
        PH_LEN2,
        PH_MSG1,
        PH_MSG2,
        PH_DATA,
        PH_CRC
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [9:0]  left_reg, left_next;
    logic [9:0]  len_reg, len_next;
    logic [11:0] msg_reg, msg_next;
    logic [9:0]  left_dec;
    logic [9:0]  len_full;

    assign left_dec = left_reg - 10'd1;
    assign len_full = {len_reg[9:8], byte_data};

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        len_next   = len_reg;
        msg_next   = msg_reg;
        push       = 1'b0;
        push_entry = '{kind: KIND_CONT, data: byte_data,
                       msg_num: msg_reg, length: len_reg};
        if (byte_valid) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (byte_data == PREAMBLE) begin
                        push            = 1'b1;
                        push_entry.kind = KIND_START;
                        phase_next      = PH_LEN1;
                    end
                end
                PH_LEN1: begin
                    if ((byte_data & LEN1_MASK) != 8'h00) begin
                        // bad header: byte is rescanned as a hunt byte
                        if (byte_data == PREAMBLE) begin
                            push            = 1'b1;
                            push_entry.kind = KIND_START;
                            phase_next      = PH_LEN1;
                        end else begin
                            phase_next = PH_HUNT;
                        end
                    end else begin
                        push       = 1'b1;
                        len_next   = {byte_data[1:0], 8'h00};
                        phase_next = PH_LEN2;
                    end
                end
                PH_LEN2: begin
                    push     = 1'b1;
                    len_next = len_full;
                    if (len_full == 10'd0) begin
                        msg_next   = 12'd0;
                        left_next  = CRC_BYTES;
                        phase_next = PH_CRC;
                    end else begin
                        left_next  = len_full;
                        phase_next = PH_MSG1;
                    end
                end
                PH_MSG1, PH_MSG2, PH_DATA: begin
                    push = 1'b1;
                    if (phase_reg == PH_MSG1) begin
                        msg_next = {byte_data, 4'h0};
                    end else if (phase_reg == PH_MSG2) begin
                        msg_next = {msg_reg[11:4], byte_data[7:4]};
                    end
                    if (left_dec == 10'd0) begin
                        left_next  = CRC_BYTES;
                        phase_next = PH_CRC;
                    end else begin
                        left_next  = left_dec;
                        phase_next = (phase_reg == PH_MSG1) ? PH_MSG2 : PH_DATA;
                    end
                end
                PH_CRC: begin
                    push      = 1'b1;
                    left_next = left_dec;
                    if (left_dec == 10'd0) begin
                        push_entry.kind = KIND_LAST;
                        phase_next      = PH_HUNT;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            left_reg  <= '0;
            len_reg   <= '0;
            msg_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            len_reg   <= len_next;
            msg_reg   <= msg_next;
        end
    end

endmodule

`default_nettype wire

[src/rtcm3_queue.sv]
// ---------------------------------------------------------------------------
// rtcm3_queue: short beat queue between parser and CRC back end
// Register-based FIFO; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rtcm3_queue
    import rtcm3_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  qentry_t   push_entry,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output qentry_t   head
);

    qentry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

[src/rtcm3_back.sv]
// ---------------------------------------------------------------------------
// rtcm3_back: CRC-24Q engine and result register
// Folds queued bytes into the CRC; issues one result beat per frame.
// ---------------------------------------------------------------------------
`default_nettype none

module rtcm3_back
    import rtcm3_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept_bad_crc,
    input  wire logic        q_valid,
    input  qentry_t          q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [23:0]      m_data
);

    logic [23:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic [23:0] data_reg, data_next;
    logic [23:0] crc_in;
    logic [23:0] crc_step;
    logic        slot_free;
    logic [1:0]  status;

    assign slot_free = !valid_reg || m_ready;
    assign q_pop     = q_valid && ((q_head.kind != KIND_LAST) || slot_free);
    assign crc_in    = (q_head.kind == KIND_START) ? 24'h000000 : crc_reg;
    assign crc_step  = crc24q_byte(crc_in, q_head.data);

    always_comb begin
        if (crc_step == 24'h000000) begin
            status = STATUS_GOOD;
        end else if (accept_bad_crc) begin
            status = STATUS_ACCEPTED;
        end else begin
            status = STATUS_REJECTED;
        end
    end

    always_comb begin
        crc_next   = crc_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (q_pop) begin
            crc_next = crc_step;
            if (q_head.kind == KIND_LAST) begin
                valid_next = 1'b1;
                data_next  = {status, q_head.length, q_head.msg_num};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

[src/rtcm3_frame_checker.sv]
// ---------------------------------------------------------------------------
// rtcm3_frame_checker: RTCM 3 transport frame checker (CRC-24Q)
// Takes one stream byte per beat, finds frames and reports each frame's
// message number, length and CRC status as one result beat.
// ---------------------------------------------------------------------------
// Throughput: one input byte per cycle while the beat queue has room.
// Result path: the parser tags the last CRC byte into the queue at the
//   accepting edge, and the CRC back end then folds it into the result
//   register; the result beat is delayed further while bytes wait in the
//   queue or the result side stalls.
// s_axis_tready drops only when the 4-deep beat queue is full.
// Reset: aresetn synchronous, active low; clears parser, queue, CRC and
//   the accept_bad_crc register; no clearing pass.
`default_nettype none

module rtcm3_frame_checker
    import rtcm3_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [11:0] message_number,
                                             // [21:12] payload_length,
                                             // [23:22] status

    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] ADDR_ACCEPT_BAD_CRC = 3'd0;

    logic    accept_bad_crc_reg;
    logic    cfg_wr;

    logic    byte_accept;
    logic    push;
    qentry_t push_entry;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    qentry_t q_head;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_bad_crc_reg <= 1'b0;
        end else if (cfg_wr && (paddr == ADDR_ACCEPT_BAD_CRC)) begin
            accept_bad_crc_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_ACCEPT_BAD_CRC) begin
            prdata = {31'd0, accept_bad_crc_reg};
        end
    end

    // ---------------- front: parse and tag ----------------
    // A beat is taken whenever the queue has room; hunt bytes are
    // consumed without a queue entry.
    assign s_axis_tready = !q_full;
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    rtcm3_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_accept),
        .byte_data  (s_axis_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    // ---------------- decoupling queue ----------------
    rtcm3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    // ---------------- back: CRC and result register ----------------
    // Non-final bytes drain even while a result waits; only the final
    // CRC byte of the next frame holds until the result slot frees.
    rtcm3_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept_bad_crc (accept_bad_crc_reg),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .m_data         (m_axis_tdata)
    );

endmodule

`default_nettype wire

[sim/rtcm3_frame_checker_test.sv]
// ---------------------------------------------------------------------------
// rtcm3_frame_checker_test: self-checking bench for the RTCM 3 frame checker
// Feeds a byte stream of RTCM 3 frames (good, bad CRC, filler, short,
// maximum length, broken headers, truncated frames and line noise) with
// random gaps and result-side stalls. A cycle-free frame tracker predicts
// each result beat, and a monitor compares every result against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtcm3_frame_checker_test;

    import rtcm3_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES    = 400;   // long result-side hold-off
    localparam int SETTLE_CYCLES  = 16;    // drain time for bytes with no result
    localparam int RANDOM_BYTES   = 100;
    localparam int CFG_EVERY      = 35;    // frame bytes between register rewrites

    localparam logic [2:0] ADDR_ACCEPT_BAD = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

    // tracker phases for the hunt, header, message number, payload and CRC bytes
    typedef enum logic [2:0] {
        SEEK   = 3'd0,
        HDR    = 3'd1,
        LEN_LO = 3'd2,
        MSG_HI = 3'd3,
        MSG_LO = 3'd4,
        BODY   = 3'd5,
        CHECK  = 3'd6
    } frame_phase_t;

    // same bit layout as m_axis_tdata: msg_num in the low bits
    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  length;
        logic [11:0] msg_num;
    } frame_report_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;             // [11:0] message_number,
                                           // [21:12] payload_length,
                                           // [23:22] status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    rtcm3_frame_checker uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Frame tracker state (mirror of the block) and pending results
    // ------------------------------------------------------------------
    frame_phase_t  trk_phase = SEEK;
    logic [23:0]   trk_crc = '0;
    logic [9:0]    trk_left = '0;
    logic [9:0]    trk_len = '0;
    logic [11:0]   trk_msg = '0;
    logic          trk_accept_bad = 1'b0;

    frame_report_t frames_due[$];
    int            error_count = 0;
    int            frame_bytes_sent = 0;

    bit            sender_calm = 1'b0;     // no gaps on the input side
    bit            hold_req = 1'b0;        // ask receiver for a long hold-off
    int            idle_cycles = 0;

    // CRC-24Q, MSB first: feedback bit form
    function automatic logic [23:0] crc24q_next(input logic [23:0] crc,
                                                input logic [7:0] b);
        logic [23:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[23] ^ b[i];
            c  = {c[22:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY[23:0];
            end
        end
        return c;
    endfunction

    task automatic seek_preamble(input logic [7:0] b);
        if (b == PREAMBLE) begin
            trk_crc   = crc24q_next(24'd0, b);
            trk_phase = HDR;
        end else begin
            trk_phase = SEEK;
        end
    endtask

    // one payload byte consumed; switch to CRC bytes when the payload ends
    task automatic count_payload(input frame_phase_t next_phase);
        trk_left = trk_left - 10'd1;
        if (trk_left == 10'd0) begin
            trk_left  = CRC_BYTES;
            trk_phase = CHECK;
        end else begin
            trk_phase = next_phase;
        end
    endtask

    // Advance the tracker by one accepted byte; queue a result at frame end.
    task automatic absorb_byte(input logic [7:0] b);
        frame_report_t rep;
        case (trk_phase)
            HDR: begin
                // bad header: that byte becomes a new hunt byte
                if ((b & LEN1_MASK) != 8'd0) begin
                    seek_preamble(b);
                end else begin
                    trk_crc   = crc24q_next(trk_crc, b);
                    trk_len   = {b[1:0], 8'h00};
                    trk_phase = LEN_LO;
                end
            end
            LEN_LO: begin
                trk_crc     = crc24q_next(trk_crc, b);
                trk_len     = {trk_len[9:8], b};
                trk_left    = trk_len;
                if (trk_len == 10'd0) begin
                    // filler frame: straight to the CRC bytes
                    trk_msg   = 12'd0;
                    trk_left  = CRC_BYTES;
                    trk_phase = CHECK;
                end else begin
                    trk_phase = MSG_HI;
                end
            end
            MSG_HI: begin
                trk_crc = crc24q_next(trk_crc, b);
                trk_msg = {b, 4'h0};
                count_payload(MSG_LO);
            end
            MSG_LO: begin
                trk_crc = crc24q_next(trk_crc, b);
                trk_msg = {trk_msg[11:4], b[7:4]};
                count_payload(BODY);
            end
            BODY: begin
                trk_crc = crc24q_next(trk_crc, b);
                count_payload(BODY);
            end
            CHECK: begin
                trk_crc  = crc24q_next(trk_crc, b);
                trk_left = trk_left - 10'd1;
                if (trk_left == 10'd0) begin
                    trk_phase   = SEEK;
                    rep.msg_num = trk_msg;
                    rep.length  = trk_len;
                    if (trk_crc == 24'd0) begin
                        rep.status = STATUS_GOOD;
                    end else if (trk_accept_bad) begin
                        rep.status = STATUS_ACCEPTED;
                    end else begin
                        rep.status = STATUS_REJECTED;
                    end
                    frames_due.push_back(rep);
                end
            end
            default: begin
                seek_preamble(b);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side: one byte per beat, random gaps after acceptance
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        absorb_byte(b);
        gap = pick_gap();
        // valid stays high into the next byte unless a gap follows
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Build and send one frame; len_keep < total truncates it.
    task automatic send_frame(input int len, input logic [11:0] msg,
                              input bit bad_crc, input int len_keep = -1);
        logic [7:0]  bytes[$];
        logic [23:0] crc;
        int          flip;
        bytes.push_back(PREAMBLE);
        bytes.push_back({6'd0, len[9:8]});
        bytes.push_back(len[7:0]);
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                bytes.push_back(msg[11:4]);
            end else if (i == 1) begin
                bytes.push_back({msg[3:0], 4'($urandom)});
            end else begin
                bytes.push_back(8'($urandom));
            end
        end
        crc = 24'd0;
        foreach (bytes[i]) begin
            crc = crc24q_next(crc, bytes[i]);
        end
        bytes.push_back(crc[23:16]);
        bytes.push_back(crc[15:8]);
        bytes.push_back(crc[7:0]);
        // one flipped bit in the CRC field always leaves a nonzero remainder
        if (bad_crc) begin
            flip = bytes.size() - 1 - $urandom_range(0, 2);
            bytes[flip] = bytes[flip] ^ (8'd1 << $urandom_range(0, 7));
        end
        if (len_keep >= 0 && len_keep < bytes.size()) begin
            bytes = bytes[0:len_keep - 1];
        end
        foreach (bytes[i]) begin
            send_byte(bytes[i]);
            frame_bytes_sent++;
        end
    endtask

    // Wait until every pending result is in, then let queued bytes that
    // carry no result drain out of the block.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // APB access: setup phase, access phase, then back to idle
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (addr == ADDR_ACCEPT_BAD) begin
            trk_accept_bad = data[0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_accept_reg();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ACCEPT_BAD;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (prdata !== {31'd0, trk_accept_bad}) begin
            $error("accept_bad_crc: expected %0d, got %0h", trk_accept_bad, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, calm stretches and the long hold-off
    // ------------------------------------------------------------------
    initial begin : result_ready_gen
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // hold off so the beat queue fills and the input stalls
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    calm_left = $urandom_range(50, 150);
                    m_axis_tready <= 1'b1;
                end else if (r < 18) begin
                    stall_left = (r < 16) ? $urandom_range(0, 2)
                                          : $urandom_range(20, 60);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Compare every result beat with the oldest pending report.
    always @(posedge aclk) begin : result_check
        frame_report_t want;
        frame_report_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (frames_due.size() == 0) begin
                $error("unexpected result beat: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = frames_due.pop_front();
                if (got.msg_num !== want.msg_num) begin
                    $error("message_number: expected %0d, got %0d",
                           want.msg_num, got.msg_num);
                    error_count++;
                end
                if (got.length !== want.length) begin
                    $error("payload_length: expected %0d, got %0d",
                           want.length, got.length);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d",
                           want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on any port
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reg_reset();
        check_accept_reg();
    endtask

    // filler, short payloads, field extremes, rejected CRC
    task automatic test_frame_shapes();
        apb_write(ADDR_ACCEPT_BAD, 32'd0);
        send_frame(0, 12'h000, 1'b0);
        send_frame(1, 12'hAB0, 1'b0);     // one byte: low nibble is zero
        send_frame(2, 12'hFFF, 1'b0);
        send_frame(3, 12'h000, 1'b0);
        send_frame(8, 12'h3EF, 1'b1);     // rejected
        send_frame(0, 12'h000, 1'b1);     // filler with bad CRC
        settle();
    endtask

    // bad header bytes restart the hunt on that same byte
    task automatic test_header_errors();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(PREAMBLE);
        send_byte(8'h04);                 // lowest illegal header bit
        send_byte(PREAMBLE);
        send_byte(8'hFF);
        send_byte(PREAMBLE);              // header is a preamble: new frame
        send_frame(4, 12'h5A5, 1'b0);
        settle();
    endtask

    task automatic test_accept_bad_crc();
        apb_write(ADDR_ACCEPT_BAD, 32'hFFFF_FFFF);   // only bit 0 counts
        check_accept_reg();
        send_frame(5, 12'h123, 1'b1);
        send_frame(5, 12'h456, 1'b0);
        settle();
        apb_write(ADDR_UNMAPPED, 32'd0);             // ignored
        check_accept_reg();
        send_frame(2, 12'h789, 1'b1);
        settle();
        apb_write(ADDR_ACCEPT_BAD, 32'hFFFF_FFFE);
        check_accept_reg();
        send_frame(6, 12'hC0F, 1'b1);
        settle();
    endtask

    // maximum length frame
    task automatic test_long_frame();
        send_frame(1023, 12'($urandom), 1'b0);
        settle();
    endtask

    task automatic test_backpressure();
        sender_calm = 1'b1;
        hold_req    = 1'b1;
        repeat (4) send_frame($urandom_range(0, 6), 12'($urandom), 1'($urandom));
        sender_calm = 1'b0;
        while (hold_req) begin
            @(posedge aclk);
        end
        settle();
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return $urandom_range(0, 4);
        end else if (r < 90) begin
            return $urandom_range(5, 30);
        end
        return $urandom_range(31, 120);
    endfunction

    // mostly well-formed frames with random content; the rest bad CRC,
    // truncated or broken frames and line noise
    task automatic test_random();
        int r;
        int len;
        int next_cfg;
        frame_bytes_sent = 0;
        next_cfg = CFG_EVERY;
        while (frame_bytes_sent < RANDOM_BYTES) begin
            if (frame_bytes_sent >= next_cfg) begin
                settle();
                apb_write(ADDR_ACCEPT_BAD, $urandom);
                next_cfg += CFG_EVERY;
            end
            sender_calm = ($urandom_range(0, 9) == 0);
            len = pick_length();
            r   = $urandom_range(0, 99);
            if (r < 70) begin
                send_frame(len, 12'($urandom), 1'b0);
            end else if (r < 82) begin
                send_frame(len, 12'($urandom), 1'b1);
            end else if (r < 86) begin
                send_frame(len, 12'($urandom), 1'b0, $urandom_range(1, len + 5));
            end else if (r < 90) begin
                send_byte(PREAMBLE);
                send_byte({6'($urandom_range(1, 63)), 2'($urandom)});
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    send_byte(($urandom_range(0, 3) == 0) ? PREAMBLE : 8'($urandom));
                end
            end
        end
        sender_calm = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reg_reset();
        test_frame_shapes();
        test_header_errors();
        test_accept_bad_crc();
        test_long_frame();
        test_backpressure();
        test_random();

        if (frames_due.size() != 0) begin
            $error("%0d result beats never arrived", frames_due.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
